/* hdl/dirty_rect_merge_table_core_assert.svh */
`ifndef DIRTY_RECT_MERGE_TABLE_CORE_ASSERT_SVH
`define DIRTY_RECT_MERGE_TABLE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DRM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/drm_pkg.sv */
package drm_pkg;

   localparam int DRM_MAX_RECTS  = 32;
   localparam int DRM_COORD_BITS = 12;
   localparam int DRM_ACTION_W   = 2;
   localparam int DRM_INDEX_W    = 5;
   localparam int DRM_COUNT_W    = 6;
   localparam int DRM_CAP_W      = 6;
   localparam logic [DRM_CAP_W-1:0] DRM_CAP_RESET = 6'd32;

   typedef enum logic [DRM_ACTION_W-1:0] {
      ACT_ADD   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   // Command broadcast to every cell of the table row.
   typedef struct packed {
      logic shift;
      logic write;
   } cell_cmd_type;

endpackage

/* hdl/drm_req_if.sv */
interface drm_req_if import drm_pkg::*; #(
   parameter int COORD_BITS = DRM_COORD_BITS
);
   logic                    valid;
   logic                    ready;
   logic [DRM_ACTION_W-1:0] action;
   logic [COORD_BITS-1:0]   left;
   logic [COORD_BITS-1:0]   top;
   logic [COORD_BITS-1:0]   right;
   logic [COORD_BITS-1:0]   bottom;
   logic [DRM_INDEX_W-1:0]  index;

   modport source (output valid, action, left, top, right, bottom, index, input ready);
   modport sink   (input valid, action, left, top, right, bottom, index, output ready);
endinterface

/* hdl/drm_rsp_if.sv */
interface drm_rsp_if import drm_pkg::*; #(
   parameter int COORD_BITS = DRM_COORD_BITS
);
   logic                   valid;
   logic                   ready;
   logic [COORD_BITS:0]    rect_left;
   logic [COORD_BITS:0]    rect_top;
   logic [COORD_BITS:0]    rect_right;
   logic [COORD_BITS:0]    rect_bottom;
   logic                   entry_valid;
   logic [DRM_COUNT_W-1:0] rect_count;

   modport source (output valid, rect_left, rect_top, rect_right, rect_bottom, entry_valid,
                   rect_count, input ready);
   modport sink   (input valid, rect_left, rect_top, rect_right, rect_bottom, entry_valid,
                   rect_count, output ready);
endinterface

/* hdl/drm_cell.sv */
module drm_cell import drm_pkg::*; #(
   parameter int BW    = 52,
   parameter int CNT_W = 6,
   parameter int POS   = 0
)(
   input  logic             clock,
   input  cell_cmd_type     cmd,
   input  logic [CNT_W-1:0] wr_pos,
   input  logic [BW-1:0]    wr_data,
   input  logic [BW-1:0]    next_data,
   output logic [BW-1:0]    data
);
   logic [BW-1:0] data_ff;
   logic [BW-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.shift) begin
         data_in = next_data;
      end
      // a write lands after the shift, so it fills the freed tail slot
      if (cmd.write && (wr_pos == CNT_W'(POS))) begin
         data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

/* hdl/drm_grow.sv */
module drm_grow import drm_pkg::*; #(
   parameter int EW    = 13,
   parameter int CNT_W = 6
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [4*EW-1:0]  u_box,
   input  logic [4*EW-1:0]  e_box,
   input  logic [CNT_W-1:0] in_idx,
   output logic             out_valid,
   output logic [4*EW-1:0]  out_box,
   output logic [CNT_W-1:0] out_idx,
   output logic [2*EW-1:0]  out_grow,
   output logic             busy
);
   localparam int L_LSB = 3 * EW;
   localparam int T_LSB = 2 * EW;
   localparam int R_LSB = EW;
   localparam int B_LSB = 0;

   logic             s1_valid_ff, s2_valid_ff;
   logic [4*EW-1:0]  s1_box_ff, s2_box_ff;
   logic [CNT_W-1:0] s1_idx_ff, s2_idx_ff;
   logic [EW-1:0]    s1_uw_ff, s1_uh_ff, s1_ew_ff, s1_eh_ff;
   logic [2*EW-1:0]  s2_ua_ff, s2_ea_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_box_ff <= u_box;
      s1_idx_ff <= in_idx;
      s1_uw_ff  <= u_box[R_LSB +: EW] - u_box[L_LSB +: EW];
      s1_uh_ff  <= u_box[B_LSB +: EW] - u_box[T_LSB +: EW];
      s1_ew_ff  <= e_box[R_LSB +: EW] - e_box[L_LSB +: EW];
      s1_eh_ff  <= e_box[B_LSB +: EW] - e_box[T_LSB +: EW];
      s2_box_ff <= s1_box_ff;
      s2_idx_ff <= s1_idx_ff;
      s2_ua_ff  <= (2*EW)'(s1_uw_ff) * (2*EW)'(s1_uh_ff);
      s2_ea_ff  <= (2*EW)'(s1_ew_ff) * (2*EW)'(s1_eh_ff);
   end

   // union contains the entry, so the difference never wraps
   assign out_valid = s2_valid_ff;
   assign out_box   = s2_box_ff;
   assign out_idx   = s2_idx_ff;
   assign out_grow  = s2_ua_ff - s2_ea_ff;
   assign busy      = s1_valid_ff | s2_valid_ff;
endmodule

/* hdl/dirty_rect_merge_table_core.sv */
// Channel | Direction | Payload
// req_ch  | in        | action, left, top, right, bottom, index
// rsp_ch  | out       | rect_left/top/right/bottom, entry_valid, rect_count
// csr     | in        | csr_wr_data = capacity
//
// Clear, read and no-op finish without a scan. An add walks the cell row one entry per
// cycle, and the scan pass repeats after every pass that absorbed an entry. If no
// pass absorbs and the table is full, a merge into the cheapest entry follows.
// Reset (synchronous) empties the table and sets capacity to 32.
// A stalled result is held until it is taken; the next command waits in its final state.
module dirty_rect_merge_table_core import drm_pkg::*; #(
   parameter int MAX_RECTS  = DRM_MAX_RECTS,
   parameter int COORD_BITS = DRM_COORD_BITS
)(
   input  logic                 clock,
   input  logic                 reset,
   drm_req_if.sink              req_ch,
   drm_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [DRM_CAP_W-1:0] csr_wr_data
);
   localparam int EW    = COORD_BITS + 1;
   localparam int BW    = 4 * EW;
   localparam int CNT_W = $clog2(MAX_RECTS + 1);
   localparam int CMP_W = (CNT_W > DRM_CAP_W) ? CNT_W : DRM_CAP_W;
   localparam int L_LSB = 3 * EW;
   localparam int T_LSB = 2 * EW;
   localparam int R_LSB = EW;
   localparam int B_LSB = 0;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_BEST  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   function automatic logic [BW-1:0] box_union(input logic [BW-1:0] a, input logic [BW-1:0] b);
      logic [EW-1:0] l, t, r, bt;
      l  = (a[L_LSB +: EW] < b[L_LSB +: EW]) ? a[L_LSB +: EW] : b[L_LSB +: EW];
      t  = (a[T_LSB +: EW] < b[T_LSB +: EW]) ? a[T_LSB +: EW] : b[T_LSB +: EW];
      r  = (a[R_LSB +: EW] > b[R_LSB +: EW]) ? a[R_LSB +: EW] : b[R_LSB +: EW];
      bt = (a[B_LSB +: EW] > b[B_LSB +: EW]) ? a[B_LSB +: EW] : b[B_LSB +: EW];
      return {l, t, r, bt};
   endfunction

   function automatic logic box_touch(input logic [BW-1:0] n, input logic [BW-1:0] e);
      logic xt, yt;
      xt = (n[L_LSB +: EW] < e[L_LSB +: EW]) ? (n[R_LSB +: EW] >= e[L_LSB +: EW])
                                             : (e[R_LSB +: EW] >= n[L_LSB +: EW]);
      yt = (n[T_LSB +: EW] < e[T_LSB +: EW]) ? (n[B_LSB +: EW] >= e[T_LSB +: EW])
                                             : (e[B_LSB +: EW] >= n[T_LSB +: EW]);
      return xt && yt;
   endfunction

   state_type state_ff, state_in;
   logic [DRM_ACTION_W-1:0] act_ff, act_in;
   logic [DRM_INDEX_W-1:0]  idx_ff, idx_in;
   logic [BW-1:0]           box_ff, box_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        pass_left_ff, pass_left_in;
   logic                    hit_ff, hit_in;
   logic [DRM_CAP_W-1:0]    cap_ff, cap_in;
   logic                    best_any_ff, best_any_in;
   logic [2*EW-1:0]         best_grow_ff, best_grow_in;
   logic [CNT_W-1:0]        best_idx_ff, best_idx_in;
   logic [BW-1:0]           best_box_ff, best_box_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]           rsp_l_ff, rsp_t_ff, rsp_r_ff, rsp_b_ff;
   logic [EW-1:0]           rsp_l_in, rsp_t_in, rsp_r_in, rsp_b_in;
   logic                    rsp_ev_ff, rsp_ev_in;
   logic [DRM_COUNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic [BW-1:0]           cell_q [MAX_RECTS];
   cell_cmd_type            cmd;
   logic [CNT_W-1:0]        wr_pos;
   logic [BW-1:0]           wr_data;

   logic [BW-1:0]           head, u_box, new_box, rd_box;
   logic                    touch, rd_ok, rsp_load;
   logic [CMP_W-1:0]        cap_eff;
   logic [COORD_BITS-1:0]   lo_x, hi_x, lo_y, hi_y;
   logic [EW-1:0]           hi_x_up;

   logic                    g_in_valid, g_valid, g_busy;
   logic [BW-1:0]           g_box;
   logic [CNT_W-1:0]        g_idx, g_in_idx;
   logic [2*EW-1:0]         g_grow;

   for (genvar k = 0; k < MAX_RECTS; k++) begin : g_cell
      logic [BW-1:0] nb;
      if (k == MAX_RECTS - 1) begin : g_last
         assign nb = cell_q[k];
      end else begin : g_mid
         assign nb = cell_q[k+1];
      end
      drm_cell #(.BW(BW), .CNT_W(CNT_W), .POS(k)) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .wr_pos    (wr_pos),
         .wr_data   (wr_data),
         .next_data (nb),
         .data      (cell_q[k])
      );
   end

   drm_grow #(.EW(EW), .CNT_W(CNT_W)) u_grow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_in_valid),
      .u_box     (u_box),
      .e_box     (head),
      .in_idx    (g_in_idx),
      .out_valid (g_valid),
      .out_box   (g_box),
      .out_idx   (g_idx),
      .out_grow  (g_grow),
      .busy      (g_busy)
   );

   assign head     = cell_q[0];
   assign u_box    = box_union(box_ff, head);
   assign touch    = box_touch(box_ff, head);
   assign g_in_idx = count_ff - pass_left_ff;

   // capacity 0 acts as 1, above the table size as the table size
   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(MAX_RECTS)) begin
         cap_eff = CMP_W'(MAX_RECTS);
      end
   end

   // horizontal alignment to 4, reversed edges swapped
   always_comb begin
      lo_x    = (req_ch.left < req_ch.right) ? req_ch.left : req_ch.right;
      hi_x    = (req_ch.left < req_ch.right) ? req_ch.right : req_ch.left;
      lo_y    = (req_ch.top < req_ch.bottom) ? req_ch.top : req_ch.bottom;
      hi_y    = (req_ch.top < req_ch.bottom) ? req_ch.bottom : req_ch.top;
      hi_x_up = EW'(hi_x) + EW'(3);
      new_box = {1'b0, lo_x[COORD_BITS-1:2], 2'b00,
                 1'b0, lo_y,
                 hi_x_up[EW-1:2], 2'b00,
                 1'b0, hi_y};
   end

   always_comb begin
      rd_box = '0;
      for (int k = 0; k < MAX_RECTS; k++) begin
         if (32'(idx_ff) == 32'(k)) begin
            rd_box = cell_q[k];
         end
      end
      rd_ok = (act_ff == ACT_READ) && (32'(idx_ff) < 32'(count_ff))
              && (32'(idx_ff) < 32'(MAX_RECTS));
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      idx_in       = idx_ff;
      box_in       = box_ff;
      count_in     = count_ff;
      pass_left_in = pass_left_ff;
      hit_in       = hit_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      best_any_in  = best_any_ff;
      best_grow_in = best_grow_ff;
      best_idx_in  = best_idx_ff;
      best_box_in  = best_box_ff;
      cmd          = '0;
      wr_pos       = count_ff - CNT_W'(1);
      wr_data      = head;
      g_in_valid   = 1'b0;

      if (g_valid && (!best_any_ff || (g_grow < best_grow_ff))) begin
         best_any_in  = 1'b1;
         best_grow_in = g_grow;
         best_idx_in  = g_idx;
         best_box_in  = g_box;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               act_in = req_ch.action;
               idx_in = req_ch.index;
               box_in = new_box;
               unique case (req_ch.action)
                  ACT_ADD: begin
                     state_in     = ST_SCAN;
                     pass_left_in = count_ff;
                     hit_in       = 1'b0;
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (pass_left_ff == '0) begin
               if (hit_ff) begin
                  pass_left_in = count_ff;
                  hit_in       = 1'b0;
               end else if (CMP_W'(count_ff) < cap_eff) begin
                  cmd.write = 1'b1;
                  wr_pos    = count_ff;
                  wr_data   = box_ff;
                  count_in  = count_ff + CNT_W'(1);
                  state_in  = ST_DONE;
               end else begin
                  pass_left_in = count_ff;
                  best_any_in  = 1'b0;
                  state_in     = ST_BEST;
               end
            end else begin
               pass_left_in = pass_left_ff - CNT_W'(1);
               cmd.shift    = 1'b1;
               if (touch) begin
                  // absorbed: drop the head, the row closes up behind it
                  box_in   = u_box;
                  count_in = count_ff - CNT_W'(1);
                  hit_in   = 1'b1;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_BEST: begin
            if (pass_left_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               pass_left_in = pass_left_ff - CNT_W'(1);
               cmd.shift    = 1'b1;
               cmd.write    = 1'b1;
               g_in_valid   = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!g_busy && !g_valid) begin
               cmd.write = 1'b1;
               wr_pos    = best_idx_ff;
               wr_data   = best_box_ff;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_l_in     = rsp_l_ff;
      rsp_t_in     = rsp_t_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_l_in     = rd_ok ? rd_box[L_LSB +: EW] : '0;
         rsp_t_in     = rd_ok ? rd_box[T_LSB +: EW] : '0;
         rsp_r_in     = rd_ok ? rd_box[R_LSB +: EW] : '0;
         rsp_b_in     = rd_ok ? rd_box[B_LSB +: EW] : '0;
         rsp_ev_in    = rd_ok;
         rsp_cnt_in   = DRM_COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pass_left_ff <= '0;
         hit_ff       <= 1'b0;
         cap_ff       <= DRM_CAP_RESET;
         best_any_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pass_left_ff <= pass_left_in;
         hit_ff       <= hit_in;
         cap_ff       <= cap_in;
         best_any_ff  <= best_any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      idx_ff       <= idx_in;
      box_ff       <= box_in;
      best_grow_ff <= best_grow_in;
      best_idx_ff  <= best_idx_in;
      best_box_ff  <= best_box_in;
      rsp_l_ff     <= rsp_l_in;
      rsp_t_ff     <= rsp_t_in;
      rsp_r_ff     <= rsp_r_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.rect_left   = rsp_l_ff;
   assign rsp_ch.rect_top    = rsp_t_ff;
   assign rsp_ch.rect_right  = rsp_r_ff;
   assign rsp_ch.rect_bottom = rsp_b_ff;
   assign rsp_ch.entry_valid = rsp_ev_ff;
   assign rsp_ch.rect_count  = rsp_cnt_ff;
endmodule

/* hdl/drm_checker.sv */
`include "dirty_rect_merge_table_core_assert.svh"

module drm_checker import drm_pkg::*; #(
   parameter int COORD_BITS = DRM_COORD_BITS
)(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [COORD_BITS:0] rect_left,
   input logic [COORD_BITS:0] rect_top,
   input logic [COORD_BITS:0] rect_right,
   input logic [COORD_BITS:0] rect_bottom,
   input logic                entry_valid
);
   `DRM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `DRM_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !entry_valid, (rect_left == '0) && (rect_top == '0) && (rect_right == '0) && (rect_bottom == '0), "edges nonzero without a valid entry")
   `DRM_ASSERT_NOW(a_ordered, clock, reset, rsp_valid && entry_valid, (rect_left <= rect_right) && (rect_top <= rect_bottom), "stored entry has reversed edges")
   `DRM_ASSERT_NOW(a_aligned, clock, reset, rsp_valid && entry_valid, (rect_left[1:0] == 2'b00) && (rect_right[1:0] == 2'b00), "stored entry not aligned to 4")
endmodule

bind dirty_rect_merge_table_core drm_checker #(.COORD_BITS(COORD_BITS)) u_drm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rect_left   (rsp_ch.rect_left),
   .rect_top    (rsp_ch.rect_top),
   .rect_right  (rsp_ch.rect_right),
   .rect_bottom (rsp_ch.rect_bottom),
   .entry_valid (rsp_ch.entry_valid)
);
